>>> rtl/core/orfr_pkg.sv
// ----------------------------------------------------------------------------
// orfr_pkg
// Shared types and constants for the overwriting ring FIFO with rewind.
// ----------------------------------------------------------------------------
package orfr_pkg;

    // store geometry
    localparam int DEPTH   = 64;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = PTR_W + 1;
    localparam int SMP_W   = 24;
    localparam int TOT_W   = 32;
    localparam int KIND_W  = 3;

    // operation codes carried in the kind field
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH      = 3'd0,
        KIND_POP       = 3'd1,
        KIND_PEEK      = 3'd2,
        KIND_REWIND    = 3'd3,
        KIND_FLUSH     = 3'd4,
        KIND_OVF_CLR   = 3'd5,
        KIND_TOTAL_CLR = 3'd6
    } t_kind;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the input word and launch the store read
        logic exec;      // apply the operation and load the result
    } t_cmd;

endpackage

>>> rtl/core/overwriting_ring_fifo_rewind.sv
// ----------------------------------------------------------------------------
// overwriting_ring_fifo_rewind
// Ring FIFO of raw 24-bit samples that overwrites the oldest entry when full,
// with pop, peek, rewind, flush and flag/total maintenance operations.
// ----------------------------------------------------------------------------
//  channel | handshake               | words
//  --------+-------------------------+------------------------------------------
//  input   | i_in_valid / o_in_stall | kind, sample_raw, peek_offset, rewind_steps
//  output  | o_out_valid/i_out_stall | ok, read_sample, rewound, fill_count,
//          |                         | is_full, overflowed, data_ready, push_total
//
//  A word passes through accept, execute and present in turn. The store's
//  registered read port sets the execute cycle after the accept.
//  A stalled result holds the block; the next word is taken once it leaves.
//  Synchronous active-low reset; the store reads as zero after reset through
//  per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module overwriting_ring_fifo_rewind
    import orfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SMP_W-1:0]  i_sample_raw,
    input  logic [PTR_W-1:0]  i_peek_offset,
    input  logic [CNT_W-1:0]  i_rewind_steps,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_ok,
    output logic [SMP_W-1:0]  o_read_sample,
    output logic [CNT_W-1:0]  o_rewound,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic              o_is_full,
    output logic              o_overflowed,
    output logic              o_data_ready,
    output logic [TOT_W-1:0]  o_push_total
);

    t_cmd cmd;

    // sequencer
    orfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // datapath
    orfr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_sample_raw   (i_sample_raw),
        .i_peek_offset  (i_peek_offset),
        .i_rewind_steps (i_rewind_steps),
        .o_ok           (o_ok),
        .o_read_sample  (o_read_sample),
        .o_rewound      (o_rewound),
        .o_fill_count   (o_fill_count),
        .o_is_full      (o_is_full),
        .o_overflowed   (o_overflowed),
        .o_data_ready   (o_data_ready),
        .o_push_total   (o_push_total)
    );

endmodule

>>> rtl/core/orfr_ram.sv
// ----------------------------------------------------------------------------
// orfr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module orfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/orfr_ctrl.sv
// ----------------------------------------------------------------------------
// orfr_ctrl
// Sequencer: accept one word, execute it, hold the result until taken.
// ----------------------------------------------------------------------------
module orfr_ctrl
    import orfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall    = 1'b1;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/core/orfr_dp.sv
// ----------------------------------------------------------------------------
// orfr_dp
// Datapath: pointers, fill count, flags, push total, sample store and the
// result registers.
// ----------------------------------------------------------------------------
module orfr_dp
    import orfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SMP_W-1:0]  i_sample_raw,
    input  logic [PTR_W-1:0]  i_peek_offset,
    input  logic [CNT_W-1:0]  i_rewind_steps,
    output logic              o_ok,
    output logic [SMP_W-1:0]  o_read_sample,
    output logic [CNT_W-1:0]  o_rewound,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic              o_is_full,
    output logic              o_overflowed,
    output logic              o_data_ready,
    output logic [TOT_W-1:0]  o_push_total
);

    // architectural state
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             r_rdy, n_rdy;
    logic [TOT_W-1:0] r_total, n_total;
    logic [DEPTH-1:0] r_vld;

    // latched word
    t_kind            r_kind;
    logic [SMP_W-1:0] r_sample;
    logic [PTR_W-1:0] r_offset;
    logic [CNT_W-1:0] r_steps;
    logic             r_rd_vld;

    // result registers
    logic             r_ok, n_ok;
    logic [SMP_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_rew, n_rew;

    // store interface
    logic [PTR_W-1:0] raddr;
    logic [SMP_W-1:0] ram_rdata;
    logic [SMP_W-1:0] rd_word;
    logic             ram_we;

    // rewind limit
    logic [CNT_W-1:0] held;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] rew_amt;

    // peek reads at an offset from the tail, everything else at the tail
    assign raddr = (t_kind'(i_kind) == KIND_PEEK) ? r_rp + i_peek_offset : r_rp;

    // never-written entries read as zero
    assign rd_word = r_rd_vld ? ram_rdata : '0;

    assign ram_we = i_cmd.exec && (r_kind == KIND_PUSH);

    orfr_ram #(
        .WIDTH (SMP_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_re    (i_cmd.capture),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // capture the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= t_kind'(i_kind);
            r_sample <= i_sample_raw;
            r_offset <= i_peek_offset;
            r_steps  <= i_rewind_steps;
            r_rd_vld <= r_vld[raddr];
        end
    end

    // rewind limit: retained entries minus unread, floored at zero
    always_comb begin
        held    = (r_total >= TOT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_total[CNT_W-1:0];
        limit   = (held > r_cnt) ? held - r_cnt : '0;
        rew_amt = (r_steps > limit) ? limit : r_steps;
    end

    // operation
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_rdy   = r_rdy;
        n_total = r_total;
        n_ok    = 1'b0;
        n_rd    = '0;
        n_rew   = '0;
        case (r_kind)
            KIND_PUSH: begin
                n_total = r_total + 1'b1;
                n_wp    = r_wp + 1'b1;
                n_rdy   = 1'b1;
                if (r_cnt < CNT_W'(DEPTH)) begin
                    n_cnt = r_cnt + 1'b1;
                    n_ok  = 1'b1;
                end else begin
                    n_rp  = r_rp + 1'b1;
                    n_ovf = 1'b1;
                end
            end
            KIND_POP: begin
                if (r_cnt != '0) begin
                    n_rd  = rd_word;
                    n_rp  = r_rp + 1'b1;
                    n_cnt = r_cnt - 1'b1;
                    n_ok  = 1'b1;
                end
            end
            KIND_PEEK: begin
                if ({1'b0, r_offset} < r_cnt) begin
                    n_rd = rd_word;
                    n_ok = 1'b1;
                end
            end
            KIND_REWIND: begin
                n_rew = rew_amt;
                n_rp  = r_rp - rew_amt[PTR_W-1:0];
                n_cnt = r_cnt + rew_amt;
            end
            KIND_FLUSH: begin
                n_wp  = '0;
                n_rp  = '0;
                n_cnt = '0;
                n_ovf = 1'b0;
                n_rdy = 1'b0;
            end
            KIND_OVF_CLR: begin
                n_ovf = 1'b0;
            end
            KIND_TOTAL_CLR: begin
                n_total = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_rdy   <= 1'b0;
            r_total <= '0;
            r_vld   <= '0;
        end else if (i_cmd.exec) begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_rdy   <= n_rdy;
            r_total <= n_total;
            if (ram_we) begin
                r_vld[r_wp] <= 1'b1;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok  <= n_ok;
            r_rd  <= n_rd;
            r_rew <= n_rew;
        end
    end

    assign o_ok          = r_ok;
    assign o_read_sample = r_rd;
    assign o_rewound     = r_rew;
    assign o_fill_count  = r_cnt;
    assign o_is_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_overflowed  = r_ovf;
    assign o_data_ready  = r_rdy;
    assign o_push_total  = r_total;

endmodule
